>>> design/assert_macros.svh
// Assertion macros for the RTL files; the core top level includes them.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

>>> design/sha_cx_pkg.sv
// Package for the counter-mode SHA-256 core: constants, types, round function.
// Used by every module of the core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sha_cx_pkg;

    localparam int LANES     = 8;
    localparam int MAX_LANES = 8;
    localparam int NUM_LANES = (LANES < 1) ? 1 : ((LANES > MAX_LANES) ? MAX_LANES : LANES);
    localparam int LANE_W    = 3;
    localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(NUM_LANES - 1);
    localparam int ROUNDS    = 64;
    localparam int QDEPTH    = 2;

    localparam logic [31:0] MSG_LEN_BITS = 32'(41 * 8);
    localparam logic [7:0]  PAD_BYTE     = 8'h80;

    typedef enum logic [2:0] {
        REG_SEED_0   = 3'd0,
        REG_SEED_1   = 3'd1,
        REG_SEED_2   = 3'd2,
        REG_SEED_3   = 3'd3,
        REG_DOMAIN   = 3'd4
    } t_reg_idx;

    typedef logic [0:7][31:0]  t_hash;
    typedef logic [0:15][31:0] t_window;

    typedef struct packed {
        logic [LANE_W-1:0] lane;
        logic              last;
    } t_lane_tag;

    typedef struct packed {
        t_hash     s;
        t_window   w;
        t_lane_tag tag;
    } t_stage;

    localparam t_hash IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'h428A2F98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hB5C0FBCF;  6'd3:  k = 32'hE9B5DBA5;
            6'd4:  k = 32'h3956C25B;  6'd5:  k = 32'h59F111F1;
            6'd6:  k = 32'h923F82A4;  6'd7:  k = 32'hAB1C5ED5;
            6'd8:  k = 32'hD807AA98;  6'd9:  k = 32'h12835B01;
            6'd10: k = 32'h243185BE;  6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74;  6'd13: k = 32'h80DEB1FE;
            6'd14: k = 32'h9BDC06A7;  6'd15: k = 32'hC19BF174;
            6'd16: k = 32'hE49B69C1;  6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6;  6'd19: k = 32'h240CA1CC;
            6'd20: k = 32'h2DE92C6F;  6'd21: k = 32'h4A7484AA;
            6'd22: k = 32'h5CB0A9DC;  6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152;  6'd25: k = 32'hA831C66D;
            6'd26: k = 32'hB00327C8;  6'd27: k = 32'hBF597FC7;
            6'd28: k = 32'hC6E00BF3;  6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27B70A85;  6'd33: k = 32'h2E1B2138;
            6'd34: k = 32'h4D2C6DFC;  6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354;  6'd37: k = 32'h766A0ABB;
            6'd38: k = 32'h81C2C92E;  6'd39: k = 32'h92722C85;
            6'd40: k = 32'hA2BFE8A1;  6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70;  6'd43: k = 32'hC76C51A3;
            6'd44: k = 32'hD192E819;  6'd45: k = 32'hD6990624;
            6'd46: k = 32'hF40E3585;  6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116;  6'd49: k = 32'h1E376C08;
            6'd50: k = 32'h2748774C;  6'd51: k = 32'h34B0BCB5;
            6'd52: k = 32'h391C0CB3;  6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F;  6'd55: k = 32'h682E6FF3;
            6'd56: k = 32'h748F82EE;  6'd57: k = 32'h78A5636F;
            6'd58: k = 32'h84C87814;  6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA;  6'd61: k = 32'hA4506CEB;
            6'd62: k = 32'hBEF9A3F7;  6'd63: k = 32'hC67178F2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One compression round plus one step of the rolling schedule window.
    function automatic t_stage sha_round(input t_stage d, input logic [5:0] t);
        t_stage      q;
        logic [31:0] a, e, big0, big1, ch, maj, t1, t2, x, y, s0, s1;
        a    = d.s[0];
        e    = d.s[4];
        big1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
        ch   = (e & d.s[5]) ^ (~e & d.s[6]);
        t1   = d.s[7] + big1 + ch + round_k(t) + d.w[0];
        big0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
        maj  = (a & d.s[1]) | (a & d.s[2]) | (d.s[1] & d.s[2]);
        t2   = big0 + maj;
        x    = d.w[1];
        y    = d.w[14];
        s0   = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
        s1   = rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10);
        q.tag  = d.tag;
        q.s[0] = t1 + t2;
        q.s[1] = d.s[0];
        q.s[2] = d.s[1];
        q.s[3] = d.s[2];
        q.s[4] = d.s[3] + t1;
        q.s[5] = d.s[4];
        q.s[6] = d.s[5];
        q.s[7] = d.s[6];
        for (int i = 0; i < 15; i++) begin
            q.w[i] = d.w[i+1];
        end
        q.w[15] = s1 + d.w[9] + s0 + d.w[0];
        return q;
    endfunction

endpackage
`default_nettype wire

>>> design/sha_cx_front.sv
// Front end: accepts start commands and queues their first counters.
// Depends on sha_cx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha_cx_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_first_counter,
    output logic             o_busy,
    input  wire logic        i_pop,
    output logic             o_head_vld,
    output logic [63:0]      o_head
);
    import sha_cx_pkg::*;

    logic [63:0] r_q [QDEPTH];
    logic        r_wr, r_rd;
    logic [1:0]  r_cnt;
    logic        push;

    assign o_busy     = (r_cnt == 2'(QDEPTH));
    assign push       = i_start && !o_busy;
    assign o_head_vld = (r_cnt != 2'd0);
    assign o_head     = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (i_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= i_first_counter;
    end

endmodule
`default_nettype wire

>>> design/sha_cx_issue.sv
// Lane sequencer: pops one counter and, while it is active, issues one message block per cycle.
// Depends on sha_cx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha_cx_issue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_head_vld,
    input  wire logic [63:0] i_head,
    output logic             o_pop,
    input  wire logic [63:0] i_seed0,
    input  wire logic [63:0] i_seed1,
    input  wire logic [63:0] i_seed2,
    input  wire logic [63:0] i_seed3,
    input  wire logic [7:0]  i_domain,
    output logic             o_vld,
    output sha_cx_pkg::t_stage o_stg
);
    import sha_cx_pkg::*;

    logic              r_act;
    logic [63:0]       r_ctr;
    logic [LANE_W-1:0] r_lane;
    logic              lane_end;

    assign lane_end = (r_lane == LAST_LANE);
    assign o_pop    = i_head_vld && (!r_act || lane_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (o_pop) begin
            r_act <= 1'b1;
        end else if (lane_end) begin
            r_act <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ctr  <= i_head;
            r_lane <= '0;
        end else begin
            r_ctr  <= r_ctr + 64'd1;
            r_lane <= r_lane + LANE_W'(1);
        end
    end

    // Build the padded block: seed, domain, counter little-endian, pad, length.
    always_comb begin
        o_vld        = r_act;
        o_stg.s      = IV;
        o_stg.w[0]   = i_seed0[63:32];
        o_stg.w[1]   = i_seed0[31:0];
        o_stg.w[2]   = i_seed1[63:32];
        o_stg.w[3]   = i_seed1[31:0];
        o_stg.w[4]   = i_seed2[63:32];
        o_stg.w[5]   = i_seed2[31:0];
        o_stg.w[6]   = i_seed3[63:32];
        o_stg.w[7]   = i_seed3[31:0];
        o_stg.w[8]   = {i_domain, r_ctr[7:0], r_ctr[15:8], r_ctr[23:16]};
        o_stg.w[9]   = {r_ctr[31:24], r_ctr[39:32], r_ctr[47:40], r_ctr[55:48]};
        o_stg.w[10]  = {r_ctr[63:56], PAD_BYTE, 16'h0000};
        o_stg.w[11]  = 32'h0;
        o_stg.w[12]  = 32'h0;
        o_stg.w[13]  = 32'h0;
        o_stg.w[14]  = 32'h0;
        o_stg.w[15]  = MSG_LEN_BITS;
        o_stg.tag.lane = r_lane;
        o_stg.tag.last = lane_end;
    end

endmodule
`default_nettype wire

>>> design/sha_cx_pipe.sv
// Back end: 64-stage unrolled SHA-256 round pipeline with final IV add.
// Depends on sha_cx_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha_cx_pipe (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_vld,
    input  sha_cx_pkg::t_stage  i_stg,
    output logic                o_vld,
    output sha_cx_pkg::t_hash   o_hash,
    output sha_cx_pkg::t_lane_tag o_tag
);
    import sha_cx_pkg::*;

    logic      r_vld [ROUNDS];
    t_stage    r_stg [ROUNDS];
    t_stage    n_stg [ROUNDS];
    logic      r_out_vld;
    t_hash     r_hash;
    t_lane_tag r_tag;

    always_comb begin
        n_stg[0] = sha_round(i_stg, 6'd0);
        for (int j = 1; j < ROUNDS; j++) begin
            n_stg[j] = sha_round(r_stg[j-1], 6'(j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < ROUNDS; j++) r_vld[j] <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
            for (int j = 1; j < ROUNDS; j++) r_vld[j] <= r_vld[j-1];
            r_out_vld <= r_vld[ROUNDS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < ROUNDS; j++) r_stg[j] <= n_stg[j];
        for (int i = 0; i < 8; i++) r_hash[i] <= r_stg[ROUNDS-1].s[i] + IV[i];
        r_tag <= r_stg[ROUNDS-1].tag;
    end

    assign o_vld  = r_out_vld;
    assign o_hash = r_hash;
    assign o_tag  = r_tag;

endmodule
`default_nettype wire

>>> design/sha256_counter_xof_41byte_core.sv
// Channel   Handshake                 Payload
// command   i_start / o_busy          i_first_counter
// config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
// result    o_valid (strobe)          o_digest_bytes_*, o_lane_index, o_last
// Each command yields 8 digests, one per cycle; the next command is popped as the
// last lane of the one before issues. The lane sequencer issues one block a cycle
// while a command is active, into a 64-round pipeline. A two-entry command queue
// holds o_busy low until it fills. Reset is synchronous, active low; no clearing pass.
// Depends on sha_cx_pkg, sha_cx_front, sha_cx_issue, sha_cx_pipe, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sha256_counter_xof_41byte_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [63:0] i_first_counter,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    output logic             o_valid,
    output logic [63:0]      o_digest_bytes_0_7,
    output logic [63:0]      o_digest_bytes_8_15,
    output logic [63:0]      o_digest_bytes_16_23,
    output logic [63:0]      o_digest_bytes_24_31,
    output logic [2:0]       o_lane_index,
    output logic             o_last
);
    import sha_cx_pkg::*;

    logic [63:0] r_seed0, r_seed1, r_seed2, r_seed3;
    logic [7:0]  r_domain;
    logic        pop, head_vld, iss_vld;
    logic [63:0] head;
    t_stage      iss_stg;
    t_hash       hash;
    t_lane_tag   tag;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed0  <= '0;
            r_seed1  <= '0;
            r_seed2  <= '0;
            r_seed3  <= '0;
            r_domain <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SEED_0: r_seed0  <= i_cfg_data;
                REG_SEED_1: r_seed1  <= i_cfg_data;
                REG_SEED_2: r_seed2  <= i_cfg_data;
                REG_SEED_3: r_seed3  <= i_cfg_data;
                REG_DOMAIN: r_domain <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    sha_cx_front u_front (
        .i_clk, .i_rst_n, .i_start, .i_first_counter, .o_busy,
        .i_pop(pop), .o_head_vld(head_vld), .o_head(head)
    );

    sha_cx_issue u_issue (
        .i_clk, .i_rst_n, .i_head_vld(head_vld), .i_head(head), .o_pop(pop),
        .i_seed0(r_seed0), .i_seed1(r_seed1), .i_seed2(r_seed2), .i_seed3(r_seed3),
        .i_domain(r_domain), .o_vld(iss_vld), .o_stg(iss_stg)
    );

    sha_cx_pipe u_pipe (
        .i_clk, .i_rst_n, .i_vld(iss_vld), .i_stg(iss_stg),
        .o_vld(o_valid), .o_hash(hash), .o_tag(tag)
    );

    assign o_digest_bytes_0_7   = {hash[0], hash[1]};
    assign o_digest_bytes_8_15  = {hash[2], hash[3]};
    assign o_digest_bytes_16_23 = {hash[4], hash[5]};
    assign o_digest_bytes_24_31 = {hash[6], hash[7]};
    assign o_lane_index         = tag.lane;
    assign o_last               = tag.last;

    `ASSERT_CLK(a_lanes_back_to_back, i_clk, i_rst_n, o_valid && !o_last |=> o_valid, "lane gap")
    `ASSERT_CLK(a_lane_step, i_clk, i_rst_n, o_valid && !o_last |=> o_lane_index == $past(o_lane_index) + 3'd1, "lane order")
    `ASSERT_CLK(a_last_lane, i_clk, i_rst_n, o_valid && o_last |-> o_lane_index == LAST_LANE, "last flag")

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Testbench for the counter-mode SHA-256 core: self-checking, with its own digest predictor.
// Depends on sha_cx_pkg and sha256_counter_xof_41byte_core.
`timescale 1ns / 1ps
module tb_top;
    import sha_cx_pkg::*;

    typedef struct {
        logic [63:0] d0, d1, d2, d3;
        logic [2:0]  lane;
        logic        last;
    } t_digest;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [63:0] i_first_counter = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        o_valid;
    logic [63:0] o_digest_bytes_0_7, o_digest_bytes_8_15;
    logic [63:0] o_digest_bytes_16_23, o_digest_bytes_24_31;
    logic [2:0]  o_lane_index;
    logic        o_last;

    logic [63:0] seed_q [4];
    logic [7:0]  domain_q;
    t_digest     digest_q [$];
    int          n_errors = 0;
    int          idle_pct = 0;
    longint      cycle_cnt = 0;

    localparam logic [31:0] K_TAB [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
        32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
        32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
        32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
        32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
        32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };
    localparam logic [31:0] H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    sha256_counter_xof_41byte_core i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Hash one counter block under the current seed and domain.
    function automatic void hash_counter(input logic [63:0] ctr, output logic [31:0] hv [8]);
        logic [7:0]  msg [64];
        logic [31:0] w [64];
        logic [31:0] s [8];
        logic [31:0] t1, t2, x, y;
        for (int i = 0; i < 64; i++) msg[i] = 8'h00;
        for (int i = 0; i < 8; i++) begin
            for (int r = 0; r < 4; r++) msg[8*r+i] = seed_q[r][63-8*i -: 8];
            msg[33+i] = ctr[8*i +: 8];
        end
        msg[32] = domain_q;
        msg[41] = PAD_BYTE;
        msg[62] = MSG_LEN_BITS[15:8];
        msg[63] = MSG_LEN_BITS[7:0];
        for (int i = 0; i < 16; i++) w[i] = {msg[4*i], msg[4*i+1], msg[4*i+2], msg[4*i+3]};
        for (int t = 16; t < 64; t++) begin
            x = w[t-15];
            y = w[t-2];
            w[t] = (ror(y, 17) ^ ror(y, 19) ^ (y >> 10)) + w[t-7]
                 + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3)) + w[t-16];
        end
        for (int i = 0; i < 8; i++) s[i] = H0[i];
        for (int t = 0; t < 64; t++) begin
            t1 = s[7] + (ror(s[4], 6) ^ ror(s[4], 11) ^ ror(s[4], 25))
               + ((s[4] & s[5]) ^ (~s[4] & s[6])) + K_TAB[t] + w[t];
            t2 = (ror(s[0], 2) ^ ror(s[0], 13) ^ ror(s[0], 22))
               + ((s[0] & s[1]) | (s[0] & s[2]) | (s[1] & s[2]));
            for (int i = 7; i > 0; i--) s[i] = s[i-1];
            s[4] = s[4] + t1;
            s[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hv[i] = s[i] + H0[i];
    endfunction

    function automatic void predict_digests(logic [63:0] first);
        logic [31:0] hv [8];
        t_digest     d;
        for (int l = 0; l < NUM_LANES; l++) begin
            hash_counter(first + 64'(l), hv);
            d.d0 = {hv[0], hv[1]};
            d.d1 = {hv[2], hv[3]};
            d.d2 = {hv[4], hv[5]};
            d.d3 = {hv[6], hv[7]};
            d.lane = 3'(l);
            d.last = (l == NUM_LANES - 1);
            digest_q.push_back(d);
        end
    endfunction

    // Leave start high after the transfer so the next command can follow at once.
    task automatic send_counter(logic [63:0] ctr);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            i_first_counter <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_first_counter <= ctr;
        do @(posedge i_clk); while (o_busy);
        predict_digests(ctr);
    endtask

    task automatic drain;
        i_start <= 1'b0;
        i_first_counter <= {$urandom, $urandom};
        wait (digest_q.size() == 0);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_SEED_0: seed_q[0] = val;
            REG_SEED_1: seed_q[1] = val;
            REG_SEED_2: seed_q[2] = val;
            REG_SEED_3: seed_q[3] = val;
            REG_DOMAIN: domain_q = val[7:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_config(logic [63:0] s0, s1, s2, s3, logic [63:0] dom);
        drain();
        write_reg(REG_SEED_0, s0);
        write_reg(REG_SEED_1, s1);
        write_reg(REG_SEED_2, s2);
        write_reg(REG_SEED_3, s3);
        write_reg(REG_DOMAIN, dom);
    endtask

    // Reset values, counter extremes, wrap across 2^64.
    task automatic test_directed;
        send_counter('0);
        send_counter('1);
        send_counter(64'hFFFF_FFFF_FFFF_FFFC);
        send_counter(64'h8000_0000_0000_0000);
        send_counter(64'h7FFF_FFFF_FFFF_FFFF);
        load_config('1, '1, '1, '1, '1);
        send_counter('0);
        send_counter('1);
        send_counter(64'hAAAA_AAAA_5555_5555);
        // upper data bits and unused indexes are ignored
        load_config(64'h0123_4567_89AB_CDEF, '0, 64'h5555_5555_AAAA_AAAA, '1,
                    64'hFFFF_FFFF_FFFF_FF5A);
        write_reg(3'd5, '1);
        write_reg(3'd7, '1);
        send_counter(64'h5555_5555_AAAA_AAAA);
        send_counter(64'hFFFF_FFFF_FFFF_FFF9);
    endtask

    task automatic test_random(int n_items, int pct);
        idle_pct = pct;
        load_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(9) == 0)
                send_counter(64'hFFFF_FFFF_FFFF_FFF8 + 64'($urandom_range(7)));
            else
                send_counter({$urandom, $urandom});
        end
        idle_pct = 0;
    endtask

    always @(posedge i_clk) begin
        t_digest d;
        if (i_rst_n && o_valid) begin
            if (digest_q.size() == 0) begin
                $error("unexpected digest, lane %0d", o_lane_index);
                n_errors++;
            end else begin
                d = digest_q.pop_front();
                if (o_digest_bytes_0_7 !== d.d0) begin
                    $error("digest_bytes_0_7 exp %h got %h", d.d0, o_digest_bytes_0_7);
                    n_errors++;
                end
                if (o_digest_bytes_8_15 !== d.d1) begin
                    $error("digest_bytes_8_15 exp %h got %h", d.d1, o_digest_bytes_8_15);
                    n_errors++;
                end
                if (o_digest_bytes_16_23 !== d.d2) begin
                    $error("digest_bytes_16_23 exp %h got %h", d.d2, o_digest_bytes_16_23);
                    n_errors++;
                end
                if (o_digest_bytes_24_31 !== d.d3) begin
                    $error("digest_bytes_24_31 exp %h got %h", d.d3, o_digest_bytes_24_31);
                    n_errors++;
                end
                if (o_lane_index !== d.lane) begin
                    $error("lane_index exp %0d got %0d", d.lane, o_lane_index);
                    n_errors++;
                end
                if (o_last !== d.last) begin
                    $error("last exp %0d got %0d", d.last, o_last);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > 400000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        for (int r = 0; r < 4; r++) seed_q[r] = '0;
        domain_q = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(110, 0);
        test_random(100, 78);
        test_random(100, 19);
        test_random(110, 0);
        drain();
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
